// ----- hdl/charge_meter_accumulator_core_macros.svh -----
// Assertion macros for the charge meter accumulator.
// Expects clk and rst_n in the scope of use.
`ifndef CHARGE_METER_ACCUMULATOR_CORE_MACROS_SVH
`define CHARGE_METER_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define CMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cma_pkg.sv -----
// Shared types and constants of the charge meter accumulator.
// No dependencies.
package cma_pkg;

  localparam int unsigned DIV_DVD_W = 48;
  localparam int unsigned DIV_DVS_W = 12;

  localparam logic [19:0] TIME_MAX     = 20'd921599;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [15:0] VSCALE_RST   = 16'd3750;
  localparam logic [15:0] ISCALE_RST   = 16'd1290;

  // charge / 3600 = ((charge >> 4) * MAH_RECIP) >> 39, exact below MAH_SAT_TOTAL
  localparam logic [47:0] MAH_SAT_TOTAL = 48'd60397977600;
  localparam logic [31:0] MAH_RECIP     = 32'd2443359173;

  localparam logic REG_VSCALE = 1'b0;
  localparam logic REG_ISCALE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VGO,
    ST_VWT,
    ST_IGO,
    ST_IWT,
    ST_STEP,
    ST_QGO,
    ST_QWT,
    ST_ADD,
    ST_MGO,
    ST_MWT,
    ST_OUT
  } cma_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- hdl/charge_meter_accumulator_core.sv -----
// Top level of the charge meter accumulator: sequencer, state and output register.
// Depends on cma_pkg, cma_div and charge_meter_accumulator_core_macros.svh.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, kind, three samples    | request in
//   out     | out_valid/out_ready, seven result fields  | result out
//   cfg     | cfg_we, cfg_idx, cfg_wdata                | register write
//
// A tick is taken in idle without leaving it. A measurement holds in_ready low until
// its result is stored: two divisions, three when a step closes, on the shared divider
// (start, one step per bit, done), then a reciprocal multiply for charge to mAh.
// Reset is synchronous; scales return to their defaults, all totals clear.
// A pending result in the output register does not block a new request; the
// sequencer holds in its last state only while that register is still full.
module charge_meter_accumulator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [9:0]  in_ref_sample,
  input  logic [9:0]  in_volt_sample,
  input  logic [9:0]  in_curr_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_voltage_mv,
  output logic [15:0] out_current_ma,
  output logic [23:0] out_charge_mah,
  output logic [7:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_secs,
  output logic        out_ref_zero,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import cma_pkg::*;

  cma_state_t state_r, state_nxt;

  logic [15:0] vscale_r, vscale_nxt;
  logic [15:0] iscale_r, iscale_nxt;
  logic [19:0] elapsed_r, elapsed_nxt;
  logic [19:0] last_r, last_nxt;
  logic [7:0]  hrs_r, hrs_nxt;
  logic [5:0]  mins_r, mins_nxt;
  logic [5:0]  secs_r, secs_nxt;
  logic [23:0] step_sum_r, step_sum_nxt;
  logic [7:0]  step_cnt_r, step_cnt_nxt;
  logic [47:0] total_r, total_nxt;

  logic [9:0]  ref_r, ref_nxt;
  logic [9:0]  volt_r, volt_nxt;
  logic [9:0]  curr_r, curr_nxt;
  logic [15:0] vmv_r, vmv_nxt;
  logic [15:0] ima_r, ima_nxt;
  logic [43:0] prod_r, prod_nxt;
  logic [63:0] mprod_r, mprod_nxt;
  logic        msat_r, msat_nxt;
  logic [23:0] mah_r, mah_nxt;

  logic        ov_r, ov_nxt;
  logic [15:0] ovmv_r, ovmv_nxt;
  logic [15:0] oima_r, oima_nxt;
  logic [23:0] omah_r, omah_nxt;
  logic [7:0]  ohrs_r, ohrs_nxt;
  logic [5:0]  omin_r, omin_nxt;
  logic [5:0]  osec_r, osec_nxt;
  logic        ozero_r, ozero_nxt;

  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DVS_W-1:0] div_divisor;
  div_sts_t             div_sts;
  logic [DIV_DVD_W-1:0] div_q;

  logic        in_acc;
  logic [19:0] delta;
  logic [25:0] vprod;
  logic [25:0] iprod;
  logic [48:0] total_sum;

  logic        time_ok;
  logic        div_wait;
  logic        step_idle;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign delta     = elapsed_r - last_r;
  assign vprod     = {16'b0, volt_r} * {10'b0, vscale_r};
  assign iprod     = {16'b0, curr_r} * {10'b0, iscale_r};
  assign total_sum = {1'b0, total_r} + {5'b0, div_q[43:0]};

  cma_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (DIV_DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_kind) state_nxt = ST_VGO;
      ST_VGO:  state_nxt = ST_VWT;
      ST_VWT:  if (div_sts.done) state_nxt = ST_IGO;
      ST_IGO:  state_nxt = ST_IWT;
      ST_IWT:  if (div_sts.done) state_nxt = ST_STEP;
      ST_STEP: state_nxt = (delta == '0) ? ST_MGO : ST_QGO;
      ST_QGO:  state_nxt = ST_QWT;
      ST_QWT:  if (div_sts.done) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_MGO;
      ST_MGO:  state_nxt = ST_MWT;
      ST_MWT:  state_nxt = ST_OUT;
      ST_OUT:  if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    vscale_nxt   = vscale_r;
    iscale_nxt   = iscale_r;
    elapsed_nxt  = elapsed_r;
    last_nxt     = last_r;
    hrs_nxt      = hrs_r;
    mins_nxt     = mins_r;
    secs_nxt     = secs_r;
    step_sum_nxt = step_sum_r;
    step_cnt_nxt = step_cnt_r;
    total_nxt    = total_r;
    ref_nxt      = ref_r;
    volt_nxt     = volt_r;
    curr_nxt     = curr_r;
    vmv_nxt      = vmv_r;
    ima_nxt      = ima_r;
    prod_nxt     = prod_r;
    mprod_nxt    = mprod_r;
    msat_nxt     = msat_r;
    mah_nxt      = mah_r;
    ov_nxt       = ov_r && !out_ready;
    ovmv_nxt     = ovmv_r;
    oima_nxt     = oima_r;
    omah_nxt     = omah_r;
    ohrs_nxt     = ohrs_r;
    omin_nxt     = omin_r;
    osec_nxt     = osec_r;
    ozero_nxt    = ozero_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    if (cfg_we) begin
      case (cfg_idx)
        REG_VSCALE: vscale_nxt = cfg_wdata;
        REG_ISCALE: iscale_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind) begin
          ref_nxt  = in_ref_sample;
          volt_nxt = in_volt_sample;
          curr_nxt = in_curr_sample;
        end else if (in_acc && (elapsed_r < TIME_MAX)) begin
          elapsed_nxt = elapsed_r + 20'd1;
          if (secs_r == 6'd59) begin
            secs_nxt = '0;
            if (mins_r == 6'd59) begin
              mins_nxt = '0;
              hrs_nxt  = hrs_r + 8'd1;
            end else begin
              mins_nxt = mins_r + 6'd1;
            end
          end else begin
            secs_nxt = secs_r + 6'd1;
          end
        end
      end
      ST_VGO: begin
        div_start    = 1'b1;
        div_dividend = {22'b0, vprod};
        div_divisor  = {2'b0, ref_r};
      end
      ST_VWT: begin
        if (div_sts.done) begin
          vmv_nxt = ((ref_r == '0) || (|div_q[47:16])) ? 16'hFFFF : div_q[15:0];
        end
      end
      ST_IGO: begin
        div_start    = 1'b1;
        div_dividend = {22'b0, iprod};
        div_divisor  = {2'b0, ref_r};
      end
      ST_IWT: begin
        if (div_sts.done) begin
          ima_nxt = ((ref_r == '0) || (|div_q[47:16])) ? 16'hFFFF : div_q[15:0];
        end
      end
      ST_STEP: begin
        if (delta == '0) begin
          if (step_cnt_r != 8'd255) begin
            step_cnt_nxt = step_cnt_r + 8'd1;
            step_sum_nxt = step_sum_r + {8'b0, ima_r};
          end
        end else begin
          prod_nxt = {20'b0, step_sum_r} * {24'b0, delta};
          last_nxt = elapsed_r;
        end
      end
      ST_QGO: begin
        div_start    = 1'b1;
        div_dividend = {4'b0, prod_r};
        div_divisor  = {4'b0, (step_cnt_r == '0) ? 8'd1 : step_cnt_r};
      end
      ST_QWT: ;
      ST_ADD: begin
        total_nxt    = total_sum[48] ? {48{1'b1}} : total_sum[47:0];
        step_sum_nxt = '0;
        step_cnt_nxt = '0;
      end
      ST_MGO: begin
        mprod_nxt = {32'b0, total_r[35:4]} * {32'b0, MAH_RECIP};
        msat_nxt  = (total_r >= MAH_SAT_TOTAL);
      end
      ST_MWT: begin
        mah_nxt = msat_r ? 24'hFFFFFF : mprod_r[62:39];
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ovmv_nxt  = vmv_r;
          oima_nxt  = ima_r;
          omah_nxt  = mah_r;
          ohrs_nxt  = hrs_r;
          omin_nxt  = mins_r;
          osec_nxt  = secs_r;
          ozero_nxt = (ref_r == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      vscale_r   <= VSCALE_RST;
      iscale_r   <= ISCALE_RST;
      elapsed_r  <= '0;
      last_r     <= '0;
      hrs_r      <= '0;
      mins_r     <= '0;
      secs_r     <= '0;
      step_sum_r <= '0;
      step_cnt_r <= '0;
      total_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      vscale_r   <= vscale_nxt;
      iscale_r   <= iscale_nxt;
      elapsed_r  <= elapsed_nxt;
      last_r     <= last_nxt;
      hrs_r      <= hrs_nxt;
      mins_r     <= mins_nxt;
      secs_r     <= secs_nxt;
      step_sum_r <= step_sum_nxt;
      step_cnt_r <= step_cnt_nxt;
      total_r    <= total_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r   <= ref_nxt;
    volt_r  <= volt_nxt;
    curr_r  <= curr_nxt;
    vmv_r   <= vmv_nxt;
    ima_r   <= ima_nxt;
    prod_r  <= prod_nxt;
    mprod_r <= mprod_nxt;
    msat_r  <= msat_nxt;
    mah_r   <= mah_nxt;
    ovmv_r  <= ovmv_nxt;
    oima_r  <= oima_nxt;
    omah_r  <= omah_nxt;
    ohrs_r  <= ohrs_nxt;
    omin_r  <= omin_nxt;
    osec_r  <= osec_nxt;
    ozero_r <= ozero_nxt;
  end

  assign out_valid      = ov_r;
  assign out_voltage_mv = ovmv_r;
  assign out_current_ma = oima_r;
  assign out_charge_mah = omah_r;
  assign out_hours      = ohrs_r;
  assign out_minutes    = omin_r;
  assign out_secs       = osec_r;
  assign out_ref_zero   = ozero_r;

  assign time_ok   = (elapsed_r <= TIME_MAX) && (mins_r < 6'd60) && (secs_r < 6'd60);
  assign div_wait  = (state_r == ST_VWT) || (state_r == ST_IWT) || (state_r == ST_QWT);
  assign step_idle = (step_sum_r == '0) && (step_cnt_r == '0) && (last_r == elapsed_r);

`include "charge_meter_accumulator_core_macros.svh"

  `CMA_ASSERT_NOW(a_time_bound, 1'b1, time_ok, "elapsed time out of range")
  `CMA_ASSERT_NOW(a_done_in_wait, div_sts.done, div_wait, "divider result outside a wait state")
  `CMA_ASSERT_NOW(a_start_idle_div, div_start, !div_sts.busy, "divider restarted while busy")
  `CMA_ASSERT_NEXT(a_step_clear, state_r == ST_ADD, step_idle, "step not closed")

endmodule

// ----- hdl/cma_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on cma_pkg for the status struct and default widths.
module cma_div #(
  parameter int unsigned DVD_W = cma_pkg::DIV_DVD_W,
  parameter int unsigned DVS_W = cma_pkg::DIV_DVS_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output cma_pkg::div_sts_t   sts,
  output logic [DVD_W-1:0]    quotient
);
  import cma_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule
